@@ design/adsrfe_pkg.sv @@
package adsrfe_pkg;

  // Field and datapath widths.
  localparam int LEN_W        = 24;
  localparam int SUS_W        = 16;
  localparam int LVL_FRAC     = 15;
  localparam int LVL_W        = LVL_FRAC + 1;
  localparam int POS_W        = 32;
  localparam int NUM_W        = LEN_W + LVL_W;
  localparam int DIV_STEPS    = LVL_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int CNT_BITS_DEF = 32;
  localparam int STG_W        = 3;
  localparam int REQ_W        = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int UPC_W        = 5;

  // Own stage codes.
  localparam logic [STG_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [STG_W-1:0] ST_ATTACK  = 3'd1;
  localparam logic [STG_W-1:0] ST_DECAY   = 3'd2;
  localparam logic [STG_W-1:0] ST_SUSTAIN = 3'd3;
  localparam logic [STG_W-1:0] ST_RELEASE = 3'd4;

  // Requested stage codes from the leading envelope.
  localparam logic [REQ_W-1:0] REQ_IDLE    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ATTACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DECAY   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SUSTAIN = 3'd3;
  localparam logic [REQ_W-1:0] REQ_HOLD    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

  localparam logic [LEN_W-1:0] ATTACK_RST  = 24'd480;
  localparam logic [LEN_W-1:0] DECAY_RST   = 24'd4800;
  localparam logic [SUS_W-1:0] SUSTAIN_RST = 16'd16384;
  localparam logic [LEN_W-1:0] RELEASE_RST = 24'd4800;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_RESYNC,
    OP_ATK_LOAD,
    OP_ATK_END,
    OP_DIFF,
    OP_FACTOR,
    OP_MUL,
    OP_DIV_STEP,
    OP_LEVEL_QUOT,
    OP_RAMP_END,
    OP_LEVEL_SUS,
    OP_LEVEL_IDLE,
    OP_FINISH
  } uop_e;

  typedef enum logic [3:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NO_INPUT,
    JC_IS_ATTACK,
    JC_IS_DECAY,
    JC_IS_SUSTAIN,
    JC_IS_RELEASE,
    JC_POS_GE_ATK,
    JC_DIFF_GE_LEN,
    JC_DIV_MORE,
    JC_OUT_BUSY
  } jcond_e;

  typedef struct packed {
    uop_e               op;
    jcond_e             jc;
    logic [UPC_W-1:0]   target;
  } ucw_t;

  typedef struct packed {
    logic no_input;
    logic is_attack;
    logic is_decay;
    logic is_sustain;
    logic is_release;
    logic pos_ge_atk;
    logic diff_ge_len;
    logic div_more;
    logic out_busy;
  } cond_t;

  // Microprogram addresses.
  localparam logic [UPC_W-1:0] A_WAIT      = 5'd0;
  localparam logic [UPC_W-1:0] A_RESYNC    = 5'd1;
  localparam logic [UPC_W-1:0] A_DISP_ATK  = 5'd2;
  localparam logic [UPC_W-1:0] A_DISP_DEC  = 5'd3;
  localparam logic [UPC_W-1:0] A_DISP_SUS  = 5'd4;
  localparam logic [UPC_W-1:0] A_DISP_REL  = 5'd5;
  localparam logic [UPC_W-1:0] A_IDLE      = 5'd6;
  localparam logic [UPC_W-1:0] A_ATK       = 5'd7;
  localparam logic [UPC_W-1:0] A_ATK_LOAD  = 5'd8;
  localparam logic [UPC_W-1:0] A_ATK_END   = 5'd9;
  localparam logic [UPC_W-1:0] A_RAMP      = 5'd10;
  localparam logic [UPC_W-1:0] A_RAMP_TEST = 5'd11;
  localparam logic [UPC_W-1:0] A_FACTOR    = 5'd12;
  localparam logic [UPC_W-1:0] A_MUL       = 5'd13;
  localparam logic [UPC_W-1:0] A_DIV       = 5'd14;
  localparam logic [UPC_W-1:0] A_QUOT      = 5'd15;
  localparam logic [UPC_W-1:0] A_OUT       = 5'd16;
  localparam logic [UPC_W-1:0] A_FINISH    = 5'd17;
  localparam logic [UPC_W-1:0] A_RAMP_END  = 5'd18;
  localparam logic [UPC_W-1:0] A_SUS       = 5'd19;

  function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucw_t w;
    unique case (addr)
      A_WAIT:      w = '{OP_TAKE,       JC_NO_INPUT,    A_WAIT};
      A_RESYNC:    w = '{OP_RESYNC,     JC_NEXT,        A_WAIT};
      A_DISP_ATK:  w = '{OP_NOP,        JC_IS_ATTACK,   A_ATK};
      A_DISP_DEC:  w = '{OP_NOP,        JC_IS_DECAY,    A_RAMP};
      A_DISP_SUS:  w = '{OP_NOP,        JC_IS_SUSTAIN,  A_SUS};
      A_DISP_REL:  w = '{OP_NOP,        JC_IS_RELEASE,  A_RAMP};
      A_IDLE:      w = '{OP_LEVEL_IDLE, JC_ALWAYS,      A_OUT};
      A_ATK:       w = '{OP_NOP,        JC_POS_GE_ATK,  A_ATK_END};
      A_ATK_LOAD:  w = '{OP_ATK_LOAD,   JC_ALWAYS,      A_DIV};
      A_ATK_END:   w = '{OP_ATK_END,    JC_ALWAYS,      A_OUT};
      A_RAMP:      w = '{OP_DIFF,       JC_NEXT,        A_WAIT};
      A_RAMP_TEST: w = '{OP_NOP,        JC_DIFF_GE_LEN, A_RAMP_END};
      A_FACTOR:    w = '{OP_FACTOR,     JC_NEXT,        A_WAIT};
      A_MUL:       w = '{OP_MUL,        JC_NEXT,        A_WAIT};
      A_DIV:       w = '{OP_DIV_STEP,   JC_DIV_MORE,    A_DIV};
      A_QUOT:      w = '{OP_LEVEL_QUOT, JC_ALWAYS,      A_OUT};
      A_OUT:       w = '{OP_NOP,        JC_OUT_BUSY,    A_OUT};
      A_FINISH:    w = '{OP_FINISH,     JC_ALWAYS,      A_WAIT};
      A_RAMP_END:  w = '{OP_RAMP_END,   JC_ALWAYS,      A_OUT};
      A_SUS:       w = '{OP_LEVEL_SUS,  JC_ALWAYS,      A_OUT};
      default:     w = '{OP_NOP,        JC_ALWAYS,      A_WAIT};
    endcase
    return w;
  endfunction

endpackage

@@ design/adsrfe_useq.sv @@
module adsrfe_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  adsrfe_pkg::cond_t cond_i,
  output adsrfe_pkg::uop_e  op_o
);
  import adsrfe_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  ucw_t             ucw;
  logic             take;

  assign ucw  = ucode_rom(upc_q);
  assign op_o = ucw.op;

  always_comb begin
    unique case (ucw.jc)
      JC_NEXT:        take = 1'b0;
      JC_ALWAYS:      take = 1'b1;
      JC_NO_INPUT:    take = cond_i.no_input;
      JC_IS_ATTACK:   take = cond_i.is_attack;
      JC_IS_DECAY:    take = cond_i.is_decay;
      JC_IS_SUSTAIN:  take = cond_i.is_sustain;
      JC_IS_RELEASE:  take = cond_i.is_release;
      JC_POS_GE_ATK:  take = cond_i.pos_ge_atk;
      JC_DIFF_GE_LEN: take = cond_i.diff_ge_len;
      JC_DIV_MORE:    take = cond_i.div_more;
      JC_OUT_BUSY:    take = cond_i.out_busy;
      default:        take = 1'b1;
    endcase
    upc_d = take ? ucw.target : upc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= A_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

@@ design/adsr_follower_envelope.sv @@
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o   requested_stage_i
// result    out        out_valid_o / out_stall_i level_o, stage_o
// config    in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// From acceptance to result, words on the release and decay ramps take the longest,
// set by the 16-step shift-subtract divider.
// The next word is accepted once the result sits in the output register.
// The output register holds a stalled result; the sequencer waits before it
// writes the next one. Reset puts the envelope in idle with level zero.
module adsr_follower_envelope #(
  parameter int COUNT_BITS = adsrfe_pkg::CNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [adsrfe_pkg::REQ_W-1:0]    requested_stage_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [adsrfe_pkg::LVL_W-1:0]    level_o,
  output logic [adsrfe_pkg::STG_W-1:0]    stage_o,
  input  logic                            cfg_we_i,
  input  logic [adsrfe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [adsrfe_pkg::LEN_W-1:0]    cfg_data_i
);
  import adsrfe_pkg::*;

  localparam int DIFF_W = (COUNT_BITS > POS_W) ? COUNT_BITS : POS_W;
  localparam logic [LVL_W-1:0] FULL = LVL_W'(1) << LVL_FRAC;

  // Configuration.
  logic [LEN_W-1:0] attack_len_q, attack_len_d;
  logic [LEN_W-1:0] decay_len_q, decay_len_d;
  logic [SUS_W-1:0] sustain_q, sustain_d;
  logic [LEN_W-1:0] release_len_q, release_len_d;

  // Envelope state.
  logic [STG_W-1:0]      own_q, own_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] rel_time_q, rel_time_d;
  logic [LVL_W-1:0]      rel_level_q, rel_level_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;

  // Working registers.
  logic [REQ_W-1:0]     req_q, req_d;
  logic [DIFF_W-1:0]    diff_q, diff_d;
  logic [LEN_W-1:0]     fa_q, fa_d;
  logic [LVL_W-1:0]     fb_q, fb_d;
  logic [LEN_W-1:0]     den_q, den_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [LVL_W-1:0] out_level_q, out_level_d;
  logic [STG_W-1:0] out_stage_q, out_stage_d;

  uop_e  op;
  cond_t cond;

  logic [LVL_W-1:0]  sus;
  logic [LEN_W-1:0]  ramp_len;
  logic [LEN_W:0]    div_trial;
  logic [LEN_W:0]    div_sub;
  logic              div_ge;
  logic [NUM_W-1:0]  product;

  assign sus      = (sustain_q > FULL) ? FULL : sustain_q;
  assign ramp_len = (own_q == ST_DECAY) ? decay_len_q : release_len_q;

  // The remainder always stays below the divisor, so one trial subtract a step.
  assign div_trial = {num_q[NUM_W-1:LVL_W], num_q[LVL_W-1]};
  assign div_sub   = div_trial - {1'b0, den_q};
  assign div_ge    = div_trial >= {1'b0, den_q};
  assign product   = fa_q * fb_q;

  always_comb begin
    cond.no_input    = !in_valid_i;
    cond.is_attack   = own_q == ST_ATTACK;
    cond.is_decay    = own_q == ST_DECAY;
    cond.is_sustain  = own_q == ST_SUSTAIN;
    cond.is_release  = own_q == ST_RELEASE;
    cond.pos_ge_atk  = pos_q >= POS_W'(attack_len_q);
    cond.diff_ge_len = diff_q >= DIFF_W'(ramp_len);
    cond.div_more    = div_cnt_q != DIV_CNT_W'(DIV_STEPS - 1);
    cond.out_busy    = out_valid_q && out_stall_i;
  end

  adsrfe_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .op_o   (op)
  );

  assign in_stall_o  = op != OP_TAKE;
  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;
  assign stage_o     = out_stage_q;

  always_comb begin
    attack_len_d  = attack_len_q;
    decay_len_d   = decay_len_q;
    sustain_d     = sustain_q;
    release_len_d = release_len_q;
    own_d         = own_q;
    pos_d         = pos_q;
    cnt_d         = cnt_q;
    rel_time_d    = rel_time_q;
    rel_level_d   = rel_level_q;
    lvl_d         = lvl_q;
    req_d         = req_q;
    diff_d        = diff_q;
    fa_d          = fa_q;
    fb_d          = fb_q;
    den_d         = den_q;
    num_d         = num_q;
    div_cnt_d     = div_cnt_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_level_d   = out_level_q;
    out_stage_d   = out_stage_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ATTACK:  attack_len_d  = cfg_data_i;
        CFG_DECAY:   decay_len_d   = cfg_data_i;
        CFG_SUSTAIN: sustain_d     = cfg_data_i[SUS_W-1:0];
        CFG_RELEASE: release_len_d = cfg_data_i;
      endcase
    end

    unique case (op)
      OP_TAKE: begin
        req_d = requested_stage_i;
      end
      OP_RESYNC: begin
        case (req_q) inside
          REQ_ATTACK: begin
            if (own_q != ST_ATTACK) begin
              own_d = ST_ATTACK;
              pos_d = '0;
            end
          end
          REQ_DECAY: begin
            if (own_q != ST_DECAY) begin
              own_d = ST_DECAY;
              pos_d = POS_W'(attack_len_q);
            end
          end
          REQ_SUSTAIN: begin
            own_d = ST_SUSTAIN;
          end
          REQ_HOLD, REQ_RELEASE: begin
            if (own_q != ST_RELEASE) begin
              own_d       = ST_RELEASE;
              rel_time_d  = cnt_q;
              rel_level_d = lvl_q;
            end
          end
          REQ_IDLE: begin
            if (own_q != ST_IDLE) begin
              own_d = ST_IDLE;
              lvl_d = '0;
            end
          end
          default: begin
          end
        endcase
      end
      OP_ATK_LOAD: begin
        num_d     = {1'b0, pos_q[LEN_W-1:0], {LVL_FRAC{1'b0}}};
        den_d     = attack_len_q;
        pos_d     = pos_q + POS_W'(1);
        div_cnt_d = '0;
      end
      OP_ATK_END: begin
        own_d = ST_DECAY;
        pos_d = POS_W'(attack_len_q);
        lvl_d = FULL;
      end
      OP_DIFF: begin
        if (own_q == ST_DECAY) begin
          diff_d = DIFF_W'(pos_q - POS_W'(attack_len_q));
        end else begin
          diff_d = DIFF_W'(cnt_q - rel_time_q);
        end
      end
      OP_FACTOR: begin
        // The ramp is still running here, so the difference fits a length.
        den_d = ramp_len;
        if (own_q == ST_DECAY) begin
          fa_d  = diff_q[LEN_W-1:0];
          fb_d  = FULL - sus;
          pos_d = pos_q + POS_W'(1);
        end else begin
          fa_d = release_len_q - diff_q[LEN_W-1:0];
          fb_d = rel_level_q;
        end
      end
      OP_MUL: begin
        num_d     = product;
        div_cnt_d = '0;
      end
      OP_DIV_STEP: begin
        num_d     = {(div_ge ? div_sub[LEN_W-1:0] : div_trial[LEN_W-1:0]),
                     num_q[LVL_W-2:0], div_ge};
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
      end
      OP_LEVEL_QUOT: begin
        // Decay counts down from full scale; the other ramps use the quotient.
        if (own_q == ST_DECAY) begin
          lvl_d = FULL - num_q[LVL_W-1:0];
        end else begin
          lvl_d = num_q[LVL_W-1:0];
        end
      end
      OP_RAMP_END: begin
        if (own_q == ST_DECAY) begin
          own_d = ST_SUSTAIN;
          lvl_d = sus;
        end else begin
          own_d = ST_IDLE;
          lvl_d = '0;
        end
      end
      OP_LEVEL_SUS: begin
        lvl_d = sus;
      end
      OP_LEVEL_IDLE: begin
        own_d = ST_IDLE;
        lvl_d = '0;
      end
      OP_FINISH: begin
        cnt_d       = cnt_q + COUNT_BITS'(1);
        out_valid_d = 1'b1;
        out_level_d = lvl_q;
        out_stage_d = own_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_len_q  <= ATTACK_RST;
      decay_len_q   <= DECAY_RST;
      sustain_q     <= SUSTAIN_RST;
      release_len_q <= RELEASE_RST;
      own_q         <= ST_IDLE;
      pos_q         <= '0;
      cnt_q         <= '0;
      rel_time_q    <= '0;
      rel_level_q   <= '0;
      lvl_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      attack_len_q  <= attack_len_d;
      decay_len_q   <= decay_len_d;
      sustain_q     <= sustain_d;
      release_len_q <= release_len_d;
      own_q         <= own_d;
      pos_q         <= pos_d;
      cnt_q         <= cnt_d;
      rel_time_q    <= rel_time_d;
      rel_level_q   <= rel_level_d;
      lvl_q         <= lvl_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    diff_q      <= diff_d;
    fa_q        <= fa_d;
    fb_q        <= fb_d;
    den_q       <= den_d;
    num_q       <= num_d;
    div_cnt_q   <= div_cnt_d;
    out_level_q <= out_level_d;
    out_stage_q <= out_stage_d;
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import adsrfe_pkg::*;

  // Requested stage codes that the leading envelope never uses.
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;
  localparam logic [LEN_W-1:0] LEN_MAX = 24'hFFFFFF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASES = 9;
  localparam int PHASE_WORDS = 36;

  class envelope_tracker;
    localparam logic [63:0] FULL = 64'd1 << LVL_FRAC;

    logic [LEN_W-1:0] atk_len;
    logic [LEN_W-1:0] dec_len;
    logic [SUS_W-1:0] sus_reg;
    logic [LEN_W-1:0] rel_len;

    logic [STG_W-1:0] stage;
    logic [POS_W-1:0] pos;
    logic [31:0]      counter;
    logic [31:0]      rel_time;
    logic [LVL_W-1:0] rel_level;
    logic [LVL_W-1:0] level;

    logic [LVL_W-1:0] want_level_q[$];
    logic [STG_W-1:0] want_stage_q[$];
    int results_seen;
    int mismatches;

    function new();
      atk_len = ATTACK_RST;
      dec_len = DECAY_RST;
      sus_reg = SUSTAIN_RST;
      rel_len = RELEASE_RST;
      stage = ST_IDLE;
      pos = '0;
      counter = '0;
      rel_time = '0;
      rel_level = '0;
      level = '0;
      results_seen = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
      case (idx)
        CFG_ATTACK:  atk_len = data;
        CFG_DECAY:   dec_len = data;
        CFG_SUSTAIN: sus_reg = data[SUS_W-1:0];
        CFG_RELEASE: rel_len = data;
        default: ;
      endcase
    endfunction

    // Resynchronize to the leading stage, then take one ramp step.
    function void follow_request(logic [REQ_W-1:0] req);
      logic [63:0] sus;
      logic [63:0] num;
      logic [31:0] d;
      logic [31:0] r;
      case (req) inside
        REQ_ATTACK: if (stage != ST_ATTACK) begin
          stage = ST_ATTACK;
          pos = '0;
        end
        REQ_DECAY: if (stage != ST_DECAY) begin
          stage = ST_DECAY;
          pos = POS_W'(atk_len);
        end
        REQ_SUSTAIN: stage = ST_SUSTAIN;
        REQ_HOLD, REQ_RELEASE: if (stage != ST_RELEASE) begin
          stage = ST_RELEASE;
          rel_time = counter;
          rel_level = level;
        end
        REQ_IDLE: if (stage != ST_IDLE) begin
          stage = ST_IDLE;
          level = '0;
        end
        default: ;
      endcase

      sus = ({48'd0, sus_reg} > FULL) ? FULL : {48'd0, sus_reg};
      case (stage)
        ST_ATTACK: begin
          if (pos < {8'd0, atk_len}) begin
            num = {32'd0, pos} * FULL;
            level = LVL_W'(num / 64'(atk_len));
            pos = pos + 1;
          end else begin
            stage = ST_DECAY;
            pos = POS_W'(atk_len);
            level = LVL_W'(FULL);
          end
        end
        ST_DECAY: begin
          d = pos - POS_W'(atk_len);
          if (d < {8'd0, dec_len}) begin
            num = 64'(d);
            num = num * (FULL - sus);
            level = LVL_W'(FULL - num / 64'(dec_len));
            pos = pos + 1;
          end else begin
            stage = ST_SUSTAIN;
            level = LVL_W'(sus);
          end
        end
        ST_SUSTAIN: level = LVL_W'(sus);
        ST_RELEASE: begin
          r = counter - rel_time;
          if (r >= {8'd0, rel_len}) begin
            level = '0;
            stage = ST_IDLE;
          end else begin
            num = 64'(rel_level);
            num = num * (64'(rel_len) - 64'(r));
            level = LVL_W'(num / 64'(rel_len));
          end
        end
        default: begin
          stage = ST_IDLE;
          level = '0;
        end
      endcase
      counter = counter + 1;
      want_level_q.push_back(level);
      want_stage_q.push_back(stage);
    endfunction

    task flag_mismatch(string what, int got, int want);
      mismatches++;
      $display("%0t mismatch on %s at word %0d: got %0d, expected %0d",
               $time, what, results_seen, got, want);
    endtask

    task compare_output(logic [LVL_W-1:0] lvl, logic [STG_W-1:0] stg);
      logic [LVL_W-1:0] want_lvl;
      logic [STG_W-1:0] want_stg;
      if (want_level_q.size() == 0) begin
        flag_mismatch("word with nothing outstanding", int'(lvl), 0);
      end else begin
        want_lvl = want_level_q.pop_front();
        want_stg = want_stage_q.pop_front();
        if (lvl !== want_lvl) flag_mismatch("level", int'(lvl), int'(want_lvl));
        if (stg !== want_stg) flag_mismatch("stage", int'(stg), int'(want_stg));
        results_seen++;
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [REQ_W-1:0]     requested_stage_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [LVL_W-1:0]     level_o;
  logic [STG_W-1:0]     stage_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [LEN_W-1:0]     cfg_data_i;

  envelope_tracker  tracker;
  logic [REQ_W-1:0] request_plan[$];
  int send_gap_pct;
  int recv_stall_pct;
  int words_taken;
  int settings_used;
  int cycle_count;

  adsr_follower_envelope dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .requested_stage_i (requested_stage_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .level_o           (level_o),
    .stage_o           (stage_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Inputs are noted before results so a word never trails its own result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.follow_request(requested_stage_i);
      if (out_valid_o && !out_stall_i) tracker.compare_output(level_o, stage_o);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[adsr_follower_envelope] ERROR");
    $finish;
  end

  task send_word(input logic [REQ_W-1:0] req);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      requested_stage_i <= REQ_W'($urandom_range(0, 7));
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    requested_stage_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_taken++;
  endtask

  task run_plan();
    while (request_plan.size() != 0) send_word(request_plan.pop_front());
    in_valid_i <= 1'b0;
    while (tracker.results_seen != words_taken) @(posedge clk_i);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.set_reg(idx, data);
  endtask

  // The sustain word carries random upper bits that the register drops.
  task program_envelope(input logic [LEN_W-1:0] atk, input logic [LEN_W-1:0] dec,
                        input logic [SUS_W-1:0] sus, input logic [LEN_W-1:0] rel);
    write_reg(CFG_ATTACK, atk);
    write_reg(CFG_DECAY, dec);
    write_reg(CFG_SUSTAIN, {8'($urandom_range(0, 255)), sus});
    write_reg(CFG_RELEASE, rel);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return LEN_W'($urandom_range(1, 12));
    else if (k < 75) return '0;
    else if (k < 90) return LEN_W'($urandom_range(13, 40));
    else if (k < 96) return LEN_W'($urandom);
    else return LEN_MAX;
  endfunction

  function automatic logic [SUS_W-1:0] pick_sustain();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return SUS_W'($urandom_range(0, 32768));
    else if (k < 70) return 16'd32768;
    else if (k < 80) return '0;
    else return SUS_W'($urandom);
  endfunction

  function automatic int repeat_count(logic [LEN_W-1:0] len);
    return (len > 11) ? $urandom_range(0, 14) : $urandom_range(0, len + 3);
  endfunction

  function automatic logic [REQ_W-1:0] noisy(logic [REQ_W-1:0] req);
    return ($urandom_range(0, 99) < 8) ? 3'($urandom_range(0, 7)) : req;
  endfunction

  // Mostly whole notes with random stage lengths; some bursts of plain noise.
  function automatic void plan_note();
    int n;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) request_plan.push_back(REQ_W'($urandom_range(0, 7)));
      return;
    end
    n = repeat_count(tracker.atk_len);
    repeat (n) request_plan.push_back(noisy(REQ_ATTACK));
    n = repeat_count(tracker.dec_len);
    repeat (n) request_plan.push_back(noisy(REQ_DECAY));
    n = $urandom_range(0, 4);
    repeat (n) request_plan.push_back(noisy(REQ_SUSTAIN));
    n = repeat_count(tracker.rel_len);
    repeat (n) request_plan.push_back(noisy($urandom_range(0, 1) ? REQ_HOLD : REQ_RELEASE));
    n = $urandom_range(0, 3);
    repeat (n) request_plan.push_back(noisy(REQ_IDLE));
  endfunction

  initial begin
    tracker = new();
    words_taken = 0;
    settings_used = 1;
    send_gap_pct = 29;
    recv_stall_pct = 67;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    requested_stage_i <= REQ_IDLE;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_ATTACK;
    cfg_data_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset lengths: every request, including the two unused codes.
    request_plan = '{REQ_IDLE, REQ_ATTACK, REQ_ATTACK, REQ_ATTACK, REQ_SPARE_A,
                     REQ_DECAY, REQ_DECAY, REQ_SPARE_B, REQ_SUSTAIN, REQ_HOLD,
                     REQ_HOLD, REQ_RELEASE, REQ_ATTACK, REQ_RELEASE, REQ_IDLE,
                     REQ_IDLE};
    run_plan();

    // Zero lengths skip their ramps; a sustain above full scale is clamped.
    program_envelope('0, '0, 16'hFFFF, '0);
    request_plan = '{REQ_ATTACK, REQ_ATTACK, REQ_DECAY, REQ_SUSTAIN, REQ_RELEASE,
                     REQ_HOLD, REQ_IDLE, REQ_ATTACK};
    run_plan();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) begin
        send_gap_pct = 67;
        recv_stall_pct = 29;
      end else if (ph == 6) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      case (ph)
        0: program_envelope(LEN_MAX, LEN_MAX, 16'd32768, LEN_MAX);
        4: program_envelope(LEN_W'($urandom_range(1, 12)), LEN_W'($urandom_range(1, 12)),
                            '0, LEN_W'($urandom_range(1, 12)));
        default: program_envelope(pick_length(), pick_length(), pick_sustain(),
                                  pick_length());
      endcase
      while (request_plan.size() < PHASE_WORDS) plan_note();
      run_plan();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.want_level_q.size() != 0)
      tracker.flag_mismatch("words never returned", tracker.want_level_q.size(), 0);
    $display("Sent %0d requested stages under %0d envelope settings; %0d results compared.",
             words_taken, settings_used, tracker.results_seen);
    $display("Mismatches: %0d.", tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("[adsr_follower_envelope] OK");
    end else begin
      $display("[adsr_follower_envelope] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/adsrfe_pkg.sv
design/adsrfe_useq.sv
design/adsr_follower_envelope.sv
tb/testbench.sv
